FILE: design/fbnp_pkg.sv
`timescale 1ns / 1ps

package fbnp_pkg;

  localparam logic [7:0]  NEWLINE_BYTE   = 8'h0A;
  localparam logic [31:0] READ_SEPARATOR = 32'h2000_0000;
  localparam logic [3:0]  N_CODE         = 4'h6;
  localparam int          WORD_NIBBLES   = 8;
  localparam int          FIFO_DEPTH     = 4;

  typedef enum logic [1:0] {
    PH_NAME = 2'd0,
    PH_SEQ  = 2'd1,
    PH_PLUS = 2'd2,
    PH_QUAL = 2'd3
  } phase_t;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  // Clears every nibble that holds the code for N.
  function automatic logic [31:0] mask_n(input logic [31:0] w);
    logic [31:0] r;
    r = w;
    for (int i = 0; i < WORD_NIBBLES; i++) begin
      if (w[i*4 +: 4] == N_CODE) begin
        r[i*4 +: 4] = 4'h0;
      end
    end
    return r;
  endfunction

endpackage

FILE: design/fbnp_parser.sv
`timescale 1ns / 1ps

module fbnp_parser import fbnp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] byte_q,
  output push_t      push
);

  phase_t      phase, phase_next;
  logic [2:0]  pos, pos_next;
  logic [31:0] buffer, buffer_next;
  logic        empty, empty_next;

  logic [4:0]  shift;
  logic [31:0] filled;

  assign shift  = {3'd7 - pos, 2'b00};
  assign filled = buffer | ({29'd0, byte_q[2:0]} << shift);

  always_comb begin
    phase_next  = phase;
    pos_next    = pos;
    buffer_next = buffer;
    empty_next  = empty;
    push        = '0;
    if (fire) begin
      if (phase != PH_SEQ) begin
        if (byte_q == NEWLINE_BYTE) begin
          phase_next = phase_t'(phase + 2'd1);
        end
      end else if (byte_q != NEWLINE_BYTE) begin
        empty_next = 1'b0;
        if (pos == 3'd7) begin
          push.count       = 2'd1;
          push.first.word  = mask_n(filled);
          push.first.last  = 1'b0;
          buffer_next      = '0;
          pos_next         = '0;
        end else begin
          buffer_next = filled;
          pos_next    = pos + 3'd1;
        end
      end else begin
        if (pos != 3'd0 || empty) begin
          push.count       = 2'd2;
          push.first.word  = mask_n(buffer);
          push.first.last  = 1'b0;
          push.second.word = READ_SEPARATOR;
          push.second.last = 1'b1;
        end else begin
          push.count      = 2'd1;
          push.first.word = READ_SEPARATOR;
          push.first.last = 1'b1;
        end
        buffer_next = '0;
        pos_next    = '0;
        empty_next  = 1'b1;
        phase_next  = PH_PLUS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_NAME;
      pos    <= '0;
      buffer <= '0;
      empty  <= 1'b1;
    end else begin
      phase  <= phase_next;
      pos    <= pos_next;
      buffer <= buffer_next;
      empty  <= empty_next;
    end
  end

endmodule

FILE: design/fbnp_out_fifo.sv
`timescale 1ns / 1ps

module fbnp_out_fifo import fbnp_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    room,
  output logic    valid,
  input  logic    stall,
  output result_t head
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;

  result_t       mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          pop;

  assign valid = (count != '0);
  assign pop   = valid && !stall;
  assign room  = (count <= CW'(DEPTH - 2));
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + AW'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      count <= count + CW'(push.count) - CW'(pop);
    end
  end

endmodule

FILE: design/fastq_base_nibble_packer_top.sv
`timescale 1ns / 1ps

// Packs the sequence lines of a FASTQ text stream into 32-bit words.
// The byte channel (byte_valid, byte_stall, char_byte) takes one text byte
// per transfer. The word channel (word_valid, word_stall, packed_word,
// end_of_read) gives eight 3-bit base codes per word, first base in the top
// nibble, with N nibbles cleared; each sequence line ends with the separator
// word 0x20000000 with end_of_read set.
// A byte is registered at its transfer and processed once the queue has room;
// the words that it gives go into the output queue, which offers them.
// The block takes one byte per cycle while byte_stall is low. A newline in a
// sequence line can give two words, which a small output queue absorbs; the
// queue drains one word per cycle while word_stall is low and holds byte_stall
// high while a byte waits and the queue has fewer than two free entries, so
// the rate is set by the output side when words pile up.
// When the receiver holds word_stall, the current word holds and the queue
// fills, after which byte transfers stop until it drains.
// Reset empties the input register and the queue and returns the parser to
// the name line of a record with an empty word.

module fastq_base_nibble_packer_top import fbnp_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  char_byte,
  output logic        word_valid,
  input  logic        word_stall,
  output logic [31:0] packed_word,
  output logic        end_of_read
);

  logic       byte_vld;
  logic [7:0] byte_q;
  logic       room;
  logic       advance;
  push_t      push;
  result_t    head;

  assign advance    = byte_vld && room;
  assign byte_stall = byte_vld && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_vld <= 1'b0;
    end else if (byte_valid && !byte_stall) begin
      byte_vld <= 1'b1;
    end else if (advance) begin
      byte_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      byte_q <= char_byte;
    end
  end

  fbnp_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .byte_q (byte_q),
    .push   (push)
  );

  fbnp_out_fifo #(
    .DEPTH (DEPTH)
  ) u_out_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .room  (room),
    .valid (word_valid),
    .stall (word_stall),
    .head  (head)
  );

  assign packed_word = head.word;
  assign end_of_read = head.last;

endmodule

FILE: design/fbnp_checker.sv
`timescale 1ns / 1ps

module fbnp_checker import fbnp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        byte_valid,
  input logic        byte_stall,
  input logic [7:0]  char_byte,
  input logic        word_valid,
  input logic        word_stall,
  input logic [31:0] packed_word,
  input logic        end_of_read
);

  a_reset_no_word: assert property (@(posedge clk) $past(rst) && !rst |-> !word_valid)
    else $error("Word offered right after reset.");

  a_reset_no_stall: assert property (@(posedge clk) $past(rst) && !rst |-> !byte_stall)
    else $error("Byte channel stalled right after reset.");

  a_separator: assert property (@(posedge clk) disable iff (rst)
    word_valid && end_of_read |-> packed_word == READ_SEPARATOR)
    else $error("End of read marked on a word that is not the separator.");

  a_word_hold: assert property (@(posedge clk) disable iff (rst)
    word_valid && word_stall |=> word_valid && $stable(packed_word)
      && $stable(end_of_read))
    else $error("Stalled word changed.");

  a_byte_hold: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_stall |=> byte_valid && $stable(char_byte))
    else $error("Stalled byte changed.");

endmodule

bind fastq_base_nibble_packer_top fbnp_checker u_fbnp_checker (
  .clk         (clk),
  .rst         (rst),
  .byte_valid  (byte_valid),
  .byte_stall  (byte_stall),
  .char_byte   (char_byte),
  .word_valid  (word_valid),
  .word_stall  (word_stall),
  .packed_word (packed_word),
  .end_of_read (end_of_read)
);

FILE: bench/fastq_base_nibble_packer_top_test.sv
`timescale 1ns / 1ps

module fastq_base_nibble_packer_top_test;
  import fbnp_pkg::*;

  localparam logic [31:0] NIBBLE_LSBS = 32'h1111_1111;
  localparam logic [31:0] ALL_N       = 32'h6666_6666;
  localparam logic [7:0]  CR_BYTE     = 8'h0D;
  localparam int          TOTAL_CHARS = 950;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  logic [7:0]  char_byte = 8'h00;
  logic        word_valid;
  logic        word_stall = 1'b0;
  logic [31:0] packed_word;
  logic        end_of_read;

  phase_t      line_phase = PH_NAME;
  logic [2:0]  nib_pos = 3'd0;
  logic [31:0] word_buf = 32'h0;
  logic        seq_empty = 1'b1;
  result_t     expected_words[$];

  int mismatches = 0;
  int sent_chars = 0;
  bit send_idle_on = 1'b1;
  bit recv_busy_on = 1'b1;
  int stall_run = 0;
  bit stall_now;

  fastq_base_nibble_packer_top DUT (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .char_byte(char_byte),
    .word_valid(word_valid),
    .word_stall(word_stall),
    .packed_word(packed_word),
    .end_of_read(end_of_read)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic logic [31:0] clear_n_nibbles(input logic [31:0] w);
    logic [31:0] hit;
    hit = ~(ALL_N ^ w);
    hit = hit & (hit >> 1) & (hit >> 2) & NIBBLE_LSBS;
    hit = hit | (hit << 1) | (hit << 2) | (hit << 3);
    return w & ~hit;
  endfunction

  task automatic predict_words(input logic [7:0] b);
    if (line_phase != PH_SEQ) begin
      if (b == NEWLINE_BYTE) begin
        line_phase = phase_t'(line_phase + 2'd1);
      end
    end else if (b != NEWLINE_BYTE) begin
      word_buf = word_buf | ({29'd0, b[2:0]} << (4 * (7 - nib_pos)));
      seq_empty = 1'b0;
      if (nib_pos == 3'd7) begin
        expected_words.push_back('{word: clear_n_nibbles(word_buf), last: 1'b0});
        word_buf = 32'h0;
        nib_pos = 3'd0;
      end else begin
        nib_pos = nib_pos + 3'd1;
      end
    end else begin
      if (nib_pos != 3'd0 || seq_empty) begin
        expected_words.push_back('{word: clear_n_nibbles(word_buf), last: 1'b0});
      end
      expected_words.push_back('{word: READ_SEPARATOR, last: 1'b1});
      word_buf = 32'h0;
      nib_pos = 3'd0;
      seq_empty = 1'b1;
      line_phase = PH_PLUS;
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!send_idle_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic send_char(input logic [7:0] b);
    int gap;
    byte_valid <= 1'b1;
    char_byte <= b;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    predict_words(b);
    sent_chars++;
    gap = pick_gap();
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic hold_bytes();
    byte_valid <= 1'b0;
  endtask

  task automatic wait_for_words();
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_text();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == NEWLINE_BYTE) ? 8'h21 : b;
  endfunction

  function automatic logic [7:0] rand_base();
    logic [7:0] letters [5] = '{"A", "C", "G", "T", "N"};
    if ($urandom_range(0, 9) < 7) return letters[$urandom_range(0, 4)];
    return rand_text();
  endfunction

  task automatic send_line(input int len, input bit as_bases);
    for (int i = 0; i < len; i++) begin
      send_char(as_bases ? rand_base() : rand_text());
    end
    if (as_bases && $urandom_range(0, 7) == 0) send_char(CR_BYTE);
    send_char(NEWLINE_BYTE);
  endtask

  task automatic send_record();
    int r;
    int seq_len;
    r = $urandom_range(0, 99);
    if (r < 10) seq_len = 0;
    else if (r < 20) seq_len = 8 * $urandom_range(1, 3);
    else if (r < 70) seq_len = $urandom_range(1, 12);
    else if (r < 90) seq_len = $urandom_range(13, 24);
    else seq_len = $urandom_range(25, 40);
    send_line($urandom_range(0, 6), 1'b0);
    send_line(seq_len, 1'b1);
    send_line($urandom_range(0, 2), 1'b0);
    send_line(($urandom_range(0, 4) == 0) ? $urandom_range(0, 40) : seq_len, 1'b0);
  endtask

  task automatic test_directed_lines();
    logic [7:0] chars[$];
    chars = '{NEWLINE_BYTE,
              8'h00, 8'hFF, "N", 8'h07, "A", "C", "G", "T", NEWLINE_BYTE,
              NEWLINE_BYTE, NEWLINE_BYTE,
              "@", NEWLINE_BYTE, NEWLINE_BYTE, NEWLINE_BYTE, NEWLINE_BYTE,
              NEWLINE_BYTE, "N", CR_BYTE, NEWLINE_BYTE, "+", NEWLINE_BYTE,
              NEWLINE_BYTE};
    foreach (chars[i]) send_char(chars[i]);
  endtask

  task automatic test_random_records(input int upto);
    while (sent_chars < upto) begin
      if ($urandom_range(0, 7) == 0) send_idle_on = !send_idle_on;
      if ($urandom_range(0, 7) == 0) recv_busy_on = !recv_busy_on;
      send_record();
    end
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 3; i++) begin
      send_record();
      hold_bytes();
      wait_for_words();
    end
  endtask

  task automatic test_noise(input int count);
    for (int i = 0; i < count; i++) begin
      send_char(($urandom_range(0, 5) == 0) ? NEWLINE_BYTE : 8'($urandom_range(0, 255)));
    end
    while (line_phase != PH_NAME) send_char(NEWLINE_BYTE);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && word_valid && !word_stall) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", 32'h0, packed_word);
      end else begin
        want = expected_words.pop_front();
        if (packed_word !== want.word) report_mismatch("packed_word", want.word, packed_word);
        if (end_of_read !== want.last) begin
          report_mismatch("end_of_read", {31'd0, want.last}, {31'd0, end_of_read});
        end
      end
    end
    if (stall_run > 0) begin
      stall_run--;
    end else begin
      stall_now = recv_busy_on && ($urandom_range(0, 2) == 0);
      if (stall_now) begin
        stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
      end else begin
        stall_run = $urandom_range(0, 6);
      end
      word_stall <= stall_now;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_lines();
    test_random_records(450);
    test_drain_pause();
    test_noise(200);
    test_random_records(TOTAL_CHARS);
    hold_bytes();
    recv_busy_on = 1'b0;
    wait_for_words();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
